@@ hdl/five_point_area_cross_ratio_macros.svh @@
// Assertion macros for the RTL file of the cross ratio block.
`ifndef FIVE_POINT_AREA_CROSS_RATIO_MACROS_SVH
`define FIVE_POINT_AREA_CROSS_RATIO_MACROS_SVH

// The consequent is checked in the same cycle as the antecedent.
`define FPACR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define FPACR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/fpacr_pkg.sv @@
`timescale 1ns / 1ps

package fpacr_pkg;

  localparam int RATIO_BITS  = 56;
  localparam int CLAMP_SCALE = 2500;
  localparam int CLAMP_BITS  = 12;

endpackage

@@ hdl/five_point_area_cross_ratio.sv @@
`timescale 1ns / 1ps
`include "five_point_area_cross_ratio_macros.svh"

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   in_p1_x .. in_p5_y, COORD_BITS each
// out_      output     out_valid / out_ready out_ratio, out_degenerate, out_saturated
//
// One request is accepted per cycle while in_ready is high.
// The divider resolves one quotient bit per stage.
// Reset is synchronous and clears only the valid bits of the pipeline and output pair.
// A stall at the output fills a skid register first and then freezes the whole pipe.

module five_point_area_cross_ratio
  import fpacr_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_p1_x,
  input  logic [COORD_BITS-1:0] in_p1_y,
  input  logic [COORD_BITS-1:0] in_p2_x,
  input  logic [COORD_BITS-1:0] in_p2_y,
  input  logic [COORD_BITS-1:0] in_p3_x,
  input  logic [COORD_BITS-1:0] in_p3_y,
  input  logic [COORD_BITS-1:0] in_p4_x,
  input  logic [COORD_BITS-1:0] in_p4_y,
  input  logic [COORD_BITS-1:0] in_p5_x,
  input  logic [COORD_BITS-1:0] in_p5_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RATIO_BITS-1:0] out_ratio,
  output logic                  out_degenerate,
  output logic                  out_saturated
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int MW = 2 * DW;
  localparam int AW = 2 * CB + 1;
  localparam int PW = 2 * AW;
  localparam int RW = RATIO_BITS;
  localparam int NW = RW + PW;
  localparam int CW = PW + CLAMP_BITS;
  localparam int EW = RW + CW;
  localparam logic [RW-1:0] RATIO_MAX = '1;

  localparam int TRI_B [4] = '{1, 3, 1, 2};
  localparam int TRI_C [4] = '{2, 4, 3, 4};

  logic en;
  logic push;

  logic          out_v_r;
  logic          skid_v_r;
  logic [RW-1:0] out_ratio_r;
  logic          out_dg_r;
  logic          out_sat_r;
  logic [RW-1:0] skid_ratio_r;
  logic          skid_dg_r;
  logic          skid_sat_r;

  assign en       = !skid_v_r;
  assign in_ready = en;

  // Stage 1: coordinate differences and the eight cross-product terms.
  logic [CB-1:0]        px [5];
  logic [CB-1:0]        py [5];
  logic signed [MW-1:0] pa_nxt [4];
  logic signed [MW-1:0] pb_nxt [4];
  logic signed [MW-1:0] pa1_r [4];
  logic signed [MW-1:0] pb1_r [4];
  logic                 v1_r;

  assign px[0] = in_p1_x;
  assign py[0] = in_p1_y;
  assign px[1] = in_p2_x;
  assign py[1] = in_p2_y;
  assign px[2] = in_p3_x;
  assign py[2] = in_p3_y;
  assign px[3] = in_p4_x;
  assign py[3] = in_p4_y;
  assign px[4] = in_p5_x;
  assign py[4] = in_p5_y;

  always_comb begin
    logic signed [DW-1:0] dx1c;
    logic signed [DW-1:0] dy1c;
    logic signed [DW-1:0] dxbc;
    logic signed [DW-1:0] dybc;
    for (int t = 0; t < 4; t++) begin
      dx1c = $signed({1'b0, px[0]}) - $signed({1'b0, px[TRI_C[t]]});
      dy1c = $signed({1'b0, py[0]}) - $signed({1'b0, py[TRI_C[t]]});
      dxbc = $signed({1'b0, px[TRI_B[t]]}) - $signed({1'b0, px[TRI_C[t]]});
      dybc = $signed({1'b0, py[TRI_B[t]]}) - $signed({1'b0, py[TRI_C[t]]});
      pa_nxt[t] = dx1c * dybc;
      pb_nxt[t] = dy1c * dxbc;
    end
  end

  // Stage 2: doubled triangle areas.
  logic [AW-1:0] area_nxt [4];
  logic [AW-1:0] area2_r [4];
  logic          v2_r;

  always_comb begin
    logic signed [MW-1:0] cr;
    logic signed [MW-1:0] neg;
    for (int t = 0; t < 4; t++) begin
      cr          = pa1_r[t] - pb1_r[t];
      neg         = -cr;
      area_nxt[t] = cr[MW-1] ? neg[AW-1:0] : cr[AW-1:0];
    end
  end

  // Stage 3: numerator and denominator area products.
  logic [PW-1:0] num3_r;
  logic [PW-1:0] den3_r;
  logic          v3_r;

  // Stage 4: range check, zero test and the clamped product.
  logic [NW-1:0] nw_nxt;
  logic [PW-1:0] hi_nxt;
  logic [PW-1:0] hi4_r;
  logic [RW-1:0] lo4_r;
  logic [PW-1:0] den4_r;
  logic [CW-1:0] p4_r;
  logic          ov4_r;
  logic          dz4_r;
  logic          v4_r;

  assign nw_nxt = NW'(num3_r) << FRAC_BITS;
  assign hi_nxt = nw_nxt[NW-1:RW];

  // Divider: index 0 is loaded from stage 4, each later index adds one quotient bit.
  logic [EW-1:0] pe;
  logic [EW-1:0] pes;
  logic          dsat;
  logic [RW-1:0] dsh;

  assign pe   = EW'(p4_r);
  assign pes  = pe << FRAC_BITS;
  assign dsh  = pes[RW-1:0];
  assign dsat = (pe >> (RW - FRAC_BITS)) != '0;

  logic [PW-1:0] rem_r [RW+1];
  logic [PW-1:0] den_r [RW+1];
  logic [RW-1:0] sh_r  [RW+1];
  logic          sat_r [RW+1];
  logic          dg_r  [RW+1];
  logic          vd_r  [RW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_r     <= 1'b0;
      vd_r[0]  <= 1'b0;
    end else if (en) begin
      v1_r     <= in_valid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      v4_r     <= v3_r;
      vd_r[0]  <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa1_r   <= pa_nxt;
      pb1_r   <= pb_nxt;
      area2_r <= area_nxt;
      num3_r  <= area2_r[0] * area2_r[1];
      den3_r  <= area2_r[2] * area2_r[3];
      hi4_r   <= hi_nxt;
      lo4_r   <= nw_nxt[RW-1:0];
      den4_r  <= den3_r;
      p4_r    <= CW'(num3_r) * CW'(CLAMP_SCALE);
      ov4_r   <= hi_nxt >= den3_r;
      dz4_r   <= den3_r == '0;
      if (dz4_r) begin
        rem_r[0] <= '0;
        den_r[0] <= PW'(1);
        sh_r[0]  <= dsh;
        sat_r[0] <= dsat;
        dg_r[0]  <= 1'b1;
      end else begin
        rem_r[0] <= hi4_r;
        den_r[0] <= den4_r;
        sh_r[0]  <= lo4_r;
        sat_r[0] <= ov4_r;
        dg_r[0]  <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_div
    logic [PW:0]   r2;
    logic [PW:0]   diff;
    logic          ge;

    assign r2   = {rem_r[k], sh_r[k][RW-1]};
    assign diff = r2 - {1'b0, den_r[k]};
    assign ge   = r2 >= {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k+1] <= 1'b0;
      end else if (en) begin
        vd_r[k+1] <= vd_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[PW-1:0] : r2[PW-1:0];
        den_r[k+1] <= den_r[k];
        sh_r[k+1]  <= {sh_r[k][RW-2:0], ge};
        sat_r[k+1] <= sat_r[k];
        dg_r[k+1]  <= dg_r[k];
      end
    end
  end

  // Output register with a skid register behind it.
  logic [RW-1:0] res_ratio;

  assign push      = en && vd_r[RW];
  assign res_ratio = sat_r[RW] ? RATIO_MAX : sh_r[RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_ratio_r <= skid_ratio_r;
        out_dg_r    <= skid_dg_r;
        out_sat_r   <= skid_sat_r;
      end else begin
        out_ratio_r <= res_ratio;
        out_dg_r    <= dg_r[RW];
        out_sat_r   <= sat_r[RW];
      end
    end else if (push) begin
      skid_ratio_r <= res_ratio;
      skid_dg_r    <= dg_r[RW];
      skid_sat_r   <= sat_r[RW];
    end
  end

  assign out_valid      = out_v_r;
  assign out_ratio      = out_ratio_r;
  assign out_degenerate = out_dg_r;
  assign out_saturated  = out_sat_r;

  `FPACR_ASSERT_SAME(a_skid_behind_out, skid_v_r, out_v_r, "skid holds a result while output is empty")
  `FPACR_ASSERT_SAME(a_skid_fill, $rose(skid_v_r), $past(out_v_r && !out_ready), "skid filled without a stall")
  `FPACR_ASSERT_NEXT(a_skid_keep, skid_v_r && !out_ready, skid_v_r, "skid result dropped during a stall")

endmodule
